@@ sv/edf_pkg.sv @@
// ----------------------------------------------------------------------------
// edf_pkg
// Shared constants, types and saturating adders for the EDF packet buffer.
// ----------------------------------------------------------------------------
package edf_pkg;

   localparam int BUFFER_DEPTH = 64;
   localparam int IDX_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
   localparam int WORD_W       = 32;

   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   localparam logic REG_CAPACITY = 1'b0;
   localparam logic [6:0] CAPACITY_RESET = 7'd4;

   typedef struct packed {
      logic load;
      logic append;
      logic drop_one;
      logic scan_start;
      logic vscan;
      logic replace;
      logic purge;
      logic purge_end;
      logic shift;
      logic shift_end;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic op_tick;
      logic cnt_zero;
      logic full;
      logic occ_zero;
      logic scan_done;
      logic any_left;
      logic rsp_free;
   } status_type;

   function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic logic [47:0] sat48(input logic [47:0] a, input logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
   endfunction

endpackage

@@ sv/edf_ram.sv @@
// ----------------------------------------------------------------------------
// edf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module edf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                           clock,
   input  logic                                           we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
   input  logic [WIDTH-1:0]                               wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
   output logic [WIDTH-1:0]                               rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/edf_ctrl.sv @@
// ----------------------------------------------------------------------------
// edf_ctrl
// Sequencer: walks arrivals copy by copy and ticks through purge and send.
// ----------------------------------------------------------------------------
module edf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  edf_pkg::status_type  status,
   output edf_pkg::cmd_type     cmd
);
   import edf_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE       = 9'b000000001,
      S_ARR        = 9'b000000010,
      S_VSCAN      = 9'b000000100,
      S_REPLACE    = 9'b000001000,
      S_PURGE_INIT = 9'b000010000,
      S_PURGE      = 9'b000100000,
      S_PURGE_END  = 9'b001000000,
      S_SHIFT      = 9'b010000000,
      S_DONE       = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_ARR;
            end
         end
         S_ARR: begin
            if (status.op_tick) begin
               state_in = S_PURGE_INIT;
            end else if (status.cnt_zero) begin
               state_in = S_DONE;
            end else if (!status.full) begin
               cmd.append = 1'b1;
            end else begin
               // full: this copy is a drop, maybe replacing the weakest entry
               cmd.drop_one = 1'b1;
               if (!status.occ_zero) begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_VSCAN;
               end
            end
         end
         S_VSCAN: begin
            cmd.vscan = 1'b1;
            if (status.scan_done) begin
               state_in = S_REPLACE;
            end
         end
         S_REPLACE: begin
            cmd.replace = 1'b1;
            state_in    = S_ARR;
         end
         S_PURGE_INIT: begin
            cmd.scan_start = 1'b1;
            state_in       = S_PURGE;
         end
         S_PURGE: begin
            cmd.purge = 1'b1;
            if (status.scan_done) begin
               state_in = S_PURGE_END;
            end
         end
         S_PURGE_END: begin
            cmd.purge_end = 1'b1;
            state_in      = status.any_left ? S_SHIFT : S_DONE;
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (status.scan_done) begin
               cmd.shift_end = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ sv/edf_datapath.sv @@
// ----------------------------------------------------------------------------
// edf_datapath
// Entry RAM, scan pointers, victim/min trackers, totals and result register.
// ----------------------------------------------------------------------------
module edf_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  edf_pkg::cmd_type           cmd,
   output edf_pkg::status_type        status,
   input  logic [edf_pkg::CNT_W-1:0]  cap_eff,
   input  logic                       req_opcode,
   input  logic [7:0]                 req_packet_count,
   input  logic [15:0]                req_packet_slack,
   input  logic [15:0]                req_packet_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_sent,
   output logic [15:0]                rsp_sent_value,
   output logic                       rsp_was_empty,
   output logic [6:0]                 rsp_fill_level,
   output logic [31:0]                rsp_arrived_total,
   output logic [31:0]                rsp_dropped_total,
   output logic [31:0]                rsp_sent_total,
   output logic [47:0]                rsp_value_total
);
   import edf_pkg::*;

   // item
   logic             op_ff;
   logic [7:0]       cnt_ff, cnt_in;
   logic [15:0]      slk_ff, val_ff;
   // buffer control
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [CNT_W-1:0] rp_ff, rp_in;
   logic [CNT_W-1:0] wp_ff, wp_in;
   logic [CNT_W-1:0] n1_ff, n1_in;
   logic             pv_ff, pv_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;
   logic             bfound_ff, bfound_in;
   logic [IDX_W-1:0] best_ff, best_in;
   logic [15:0]      bslk_ff, bslk_in;
   logic [15:0]      bval_ff, bval_in;
   // totals
   logic [31:0]      arr_ff, arr_in;
   logic [31:0]      drp_ff, drp_in;
   logic [31:0]      snt_ff, snt_in;
   logic [47:0]      vsum_ff, vsum_in;
   // result flags
   logic             rsent_ff, rsent_in;
   logic [15:0]      rval_ff, rval_in;
   logic             rempty_ff, rempty_in;
   // response register
   logic             ov_ff, ov_in;
   logic             osent_ff;
   logic [15:0]      oval_ff;
   logic             oempty_ff;
   logic [6:0]       ofill_ff;
   logic [31:0]      oarr_ff, odrp_ff, osnt_ff;
   logic [47:0]      ovsum_ff;
   // ram
   logic              we;
   logic [IDX_W-1:0]  waddr;
   logic [WORD_W-1:0] wdata;
   logic [WORD_W-1:0] rdata;
   logic [15:0]       rd_slk, rd_val, dec_slk;
   logic              issue;
   logic [8:0]        cap_w;

   edf_ram #(.WIDTH(WORD_W), .DEPTH(BUFFER_DEPTH)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (rp_ff[IDX_W-1:0]),
      .rdata (rdata)
   );

   assign rd_slk  = rdata[31:16];
   assign rd_val  = rdata[15:0];
   assign dec_slk = rd_slk - 16'd1;
   assign issue   = (rp_ff < occ_ff);
   assign cap_w   = 9'(cap_eff);

   assign status.op_tick   = op_ff;
   assign status.cnt_zero  = (cnt_ff == 8'd0);
   assign status.full      = (occ_ff >= cap_eff);
   assign status.occ_zero  = (occ_ff == '0);
   assign status.scan_done = !issue && !pv_ff;
   assign status.any_left  = (wp_ff != '0);
   assign status.rsp_free  = !ov_ff || rsp_ready;

   always_comb begin
      cnt_in    = cnt_ff;
      occ_in    = occ_ff;
      rp_in     = rp_ff;
      wp_in     = wp_ff;
      n1_in     = n1_ff;
      pv_in     = 1'b0;
      pidx_in   = rp_ff[IDX_W-1:0];
      bfound_in = bfound_ff;
      best_in   = best_ff;
      bslk_in   = bslk_ff;
      bval_in   = bval_ff;
      arr_in    = arr_ff;
      drp_in    = drp_ff;
      snt_in    = snt_ff;
      vsum_in   = vsum_ff;
      rsent_in  = rsent_ff;
      rval_in   = rval_ff;
      rempty_in = rempty_ff;
      ov_in     = ov_ff;
      we        = 1'b0;
      waddr     = occ_ff[IDX_W-1:0];
      wdata     = {slk_ff, val_ff};

      if (ov_ff && rsp_ready) begin
         ov_in = 1'b0;
      end

      if (cmd.load) begin
         rsent_in  = 1'b0;
         rval_in   = 16'd0;
         rempty_in = 1'b0;
         cnt_in    = 8'd0;
         if (req_opcode == OP_ARRIVAL) begin
            arr_in = sat32(arr_ff, 32'(req_packet_count));
            if (9'(req_packet_count) > cap_w) begin
               drp_in = sat32(drp_ff, 32'(9'(req_packet_count) - cap_w));
               cnt_in = cap_w[7:0];
            end else begin
               cnt_in = req_packet_count;
            end
         end
      end

      if (cmd.append) begin
         we     = 1'b1;
         occ_in = occ_ff + 1'b1;
         cnt_in = cnt_ff - 8'd1;
      end

      if (cmd.drop_one) begin
         drp_in = sat32(drp_ff, 32'd1);
         cnt_in = cnt_ff - 8'd1;
      end

      if (cmd.scan_start) begin
         rp_in     = '0;
         wp_in     = '0;
         n1_in     = '0;
         bfound_in = 1'b0;
      end

      if (cmd.vscan || cmd.purge || cmd.shift) begin
         if (issue) begin
            pv_in = 1'b1;
            rp_in = rp_ff + 1'b1;
         end
      end

      // latest entry with the smallest slack
      if (cmd.vscan && pv_ff) begin
         if (!bfound_ff || rd_slk <= bslk_ff) begin
            bfound_in = 1'b1;
            best_in   = pidx_ff;
            bslk_in   = rd_slk;
         end
      end

      if (cmd.replace && bslk_ff < slk_ff) begin
         we    = 1'b1;
         waddr = best_ff;
      end

      // both purges and the decrement in one compacting pass
      if (cmd.purge && pv_ff) begin
         if (rd_slk != 16'd0) begin
            n1_in = n1_ff + 1'b1;
         end
         if (rd_slk == 16'd0 || rd_slk == 16'd1) begin
            drp_in = sat32(drp_ff, 32'd1);
         end else begin
            we    = 1'b1;
            waddr = wp_ff[IDX_W-1:0];
            wdata = {dec_slk, rd_val};
            wp_in = wp_ff + 1'b1;
            if (!bfound_ff || dec_slk < bslk_ff) begin
               bfound_in = 1'b1;
               best_in   = wp_ff[IDX_W-1:0];
               bslk_in   = dec_slk;
               bval_in   = rd_val;
            end
         end
      end

      if (cmd.purge_end) begin
         occ_in    = wp_ff;
         rempty_in = (n1_ff == '0);
         rp_in     = CNT_W'(best_ff) + 1'b1;
         if (wp_ff != '0) begin
            rsent_in = 1'b1;
            rval_in  = bval_ff;
            vsum_in  = sat48(vsum_ff, 48'(bval_ff));
            snt_in   = sat32(snt_ff, 32'd1);
         end
      end

      // close the gap left by the sent entry
      if (cmd.shift && pv_ff) begin
         we    = 1'b1;
         waddr = pidx_ff - 1'b1;
         wdata = rdata;
      end

      if (cmd.shift_end) begin
         occ_in = occ_ff - 1'b1;
      end

      if (cmd.finish) begin
         ov_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         arr_ff <= '0;
         drp_ff <= '0;
         snt_ff <= '0;
         vsum_ff <= '0;
         ov_ff  <= 1'b0;
         pv_ff  <= 1'b0;
         op_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         occ_ff  <= occ_in;
         arr_ff  <= arr_in;
         drp_ff  <= drp_in;
         snt_ff  <= snt_in;
         vsum_ff <= vsum_in;
         ov_ff   <= ov_in;
         pv_ff   <= pv_in;
         cnt_ff  <= cnt_in;
         if (cmd.load) begin
            op_ff <= req_opcode;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         slk_ff <= req_packet_slack;
         val_ff <= req_packet_value;
      end
      rp_ff     <= rp_in;
      wp_ff     <= wp_in;
      n1_ff     <= n1_in;
      pidx_ff   <= pidx_in;
      bfound_ff <= bfound_in;
      best_ff   <= best_in;
      bslk_ff   <= bslk_in;
      bval_ff   <= bval_in;
      rsent_ff  <= rsent_in;
      rval_ff   <= rval_in;
      rempty_ff <= rempty_in;
      if (cmd.finish) begin
         osent_ff  <= rsent_ff;
         oval_ff   <= rval_ff;
         oempty_ff <= rempty_ff;
         ofill_ff  <= 7'(occ_ff);
         oarr_ff   <= arr_ff;
         odrp_ff   <= drp_ff;
         osnt_ff   <= snt_ff;
         ovsum_ff  <= vsum_ff;
      end
   end

   assign rsp_valid         = ov_ff;
   assign rsp_sent          = osent_ff;
   assign rsp_sent_value    = oval_ff;
   assign rsp_was_empty     = oempty_ff;
   assign rsp_fill_level    = ofill_ff;
   assign rsp_arrived_total = oarr_ff;
   assign rsp_dropped_total = odrp_ff;
   assign rsp_sent_total    = osnt_ff;
   assign rsp_value_total   = ovsum_ff;

endmodule

@@ sv/edf_packet_buffer_scheduler.sv @@
// An arrival handles its copies one by one; a copy that meets a full buffer with
// entries in it scans them all for the weakest one. A tick scans once to purge and,
// when an entry is sent, once more to shift the entries behind it.
// One item is in work at a time; the scans of the entry RAM set the rate.
// A result waits in an output register while the next word is accepted.
// Reset (synchronous) empties the buffer, clears totals, sets capacity to 4.
// ----------------------------------------------------------------------------
// edf_packet_buffer_scheduler
// Bounded earliest-deadline-first packet buffer with APB-style capacity port.
// ----------------------------------------------------------------------------
module edf_packet_buffer_scheduler (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_opcode,
   input  logic [7:0]   req_packet_count,
   input  logic [15:0]  req_packet_slack,
   input  logic [15:0]  req_packet_value,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_sent,
   output logic [15:0]  rsp_sent_value,
   output logic         rsp_was_empty,
   output logic [6:0]   rsp_fill_level,
   output logic [31:0]  rsp_arrived_total,
   output logic [31:0]  rsp_dropped_total,
   output logic [31:0]  rsp_sent_total,
   output logic [47:0]  rsp_value_total,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);
   import edf_pkg::*;

   logic [6:0]       cap_ff;
   logic [CNT_W-1:0] cap_eff;
   cmd_type          cmd;
   status_type       status;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAPACITY_RESET;
      end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
         cap_ff <= pwdata[6:0];
      end
   end

   assign prdata  = (paddr[2] == REG_CAPACITY) ? {25'd0, cap_ff} : 32'd0;
   // clamp to the physical depth
   assign cap_eff = (32'(cap_ff) > BUFFER_DEPTH) ? CNT_W'(BUFFER_DEPTH) : CNT_W'(cap_ff);

   edf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   edf_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .cap_eff           (cap_eff),
      .req_opcode        (req_opcode),
      .req_packet_count  (req_packet_count),
      .req_packet_slack  (req_packet_slack),
      .req_packet_value  (req_packet_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sent          (rsp_sent),
      .rsp_sent_value    (rsp_sent_value),
      .rsp_was_empty     (rsp_was_empty),
      .rsp_fill_level    (rsp_fill_level),
      .rsp_arrived_total (rsp_arrived_total),
      .rsp_dropped_total (rsp_dropped_total),
      .rsp_sent_total    (rsp_sent_total),
      .rsp_value_total   (rsp_value_total)
   );

endmodule

@@ tb/tb_edf_packet_buffer_scheduler.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_edf_packet_buffer_scheduler
// Drives arrival and tick words into the EDF packet buffer and checks every
// result word against a cycle-free model of the buffer, across capacities.
// ----------------------------------------------------------------------------
module tb_edf_packet_buffer_scheduler;
   import edf_pkg::*;

   typedef struct {
      logic        opcode;
      logic [7:0]  count;
      logic [15:0] slack;
      logic [15:0] value;
   } pkt_word_type;

   typedef struct packed {
      logic        sent;
      logic [15:0] sent_value;
      logic        was_empty;
      logic [6:0]  fill_level;
      logic [31:0] arrived_total;
      logic [31:0] dropped_total;
      logic [31:0] sent_total;
      logic [47:0] value_total;
   } sched_rsp_type;

   typedef struct {
      pkt_word_type  w;
      bit            typed;
      sched_rsp_type r;
   } dir_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   logic req_opcode = 0;
   logic [7:0] req_packet_count = 0;
   logic [15:0] req_packet_slack = 0, req_packet_value = 0;
   logic rsp_valid, rsp_ready = 0;
   logic rsp_sent, rsp_was_empty;
   logic [15:0] rsp_sent_value;
   logic [6:0] rsp_fill_level;
   logic [31:0] rsp_arrived_total, rsp_dropped_total, rsp_sent_total;
   logic [47:0] rsp_value_total;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [2:0] paddr = 0;
   logic [31:0] pwdata = 0, prdata;
   logic pready;

   edf_packet_buffer_scheduler u_dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // buffer model state
   logic [15:0] m_slack[BUFFER_DEPTH];
   logic [15:0] m_value[BUFFER_DEPTH];
   int          m_occ;
   logic [31:0] m_arrived, m_dropped, m_sent;
   logic [47:0] m_vsum;
   int          m_cap;

   sched_rsp_type pending_rsp[$];
   int errors = 0;
   bit stim_done = 0;

   function automatic logic [31:0] add32(logic [31:0] a, longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic void purge_expired();
      int w;
      w = 0;
      for (int r = 0; r < m_occ; r++) begin
         if (m_slack[r] == 0) begin
            m_dropped = add32(m_dropped, 1);
         end else begin
            m_slack[w] = m_slack[r];
            m_value[w] = m_value[r];
            w++;
         end
      end
      m_occ = w;
   endfunction

   function automatic sched_rsp_type apply_word(pkt_word_type w);
      sched_rsp_type r;
      int cap, n, best;
      r.sent = 0; r.sent_value = 0; r.was_empty = 0;
      if (w.opcode == OP_ARRIVAL) begin
         cap = (m_cap > BUFFER_DEPTH) ? BUFFER_DEPTH : m_cap;
         n = int'(w.count);
         m_arrived = add32(m_arrived, n);
         if (n > cap) begin
            m_dropped = add32(m_dropped, n - cap);
            n = cap;
         end
         for (int k = 0; k < n; k++) begin
            if (m_occ < cap) begin
               m_slack[m_occ] = w.slack;
               m_value[m_occ] = w.value;
               m_occ++;
            end else begin
               m_dropped = add32(m_dropped, 1);
               if (m_occ != 0) begin
                  best = 0;
                  for (int i = 1; i < m_occ; i++)
                     if (m_slack[i] <= m_slack[best]) best = i;
                  if (m_slack[best] < w.slack) begin
                     m_slack[best] = w.slack;
                     m_value[best] = w.value;
                  end
               end
            end
         end
      end else begin
         purge_expired();
         if (m_occ == 0) begin
            r.was_empty = 1;
         end else begin
            for (int i = 0; i < m_occ; i++) m_slack[i]--;
            purge_expired();
            if (m_occ > 0) begin
               best = 0;
               for (int i = 1; i < m_occ; i++)
                  if (m_slack[i] < m_slack[best]) best = i;
               r.sent = 1;
               r.sent_value = m_value[best];
               m_vsum = ({1'b0, m_vsum} + m_value[best] > 49'hFFFF_FFFF_FFFF) ?
                        48'hFFFF_FFFF_FFFF : m_vsum + m_value[best];
               m_sent = add32(m_sent, 1);
               for (int i = best; i + 1 < m_occ; i++) begin
                  m_slack[i] = m_slack[i + 1];
                  m_value[i] = m_value[i + 1];
               end
               m_occ--;
            end
         end
      end
      r.fill_level = m_occ[6:0];
      r.arrived_total = m_arrived;
      r.dropped_total = m_dropped;
      r.sent_total = m_sent;
      r.value_total = m_vsum;
      return r;
   endfunction

   function automatic int gap_len();
      int g;
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) g = 0;
      return g;
   endfunction

   task automatic send_word(pkt_word_type w, bit typed, sched_rsp_type typed_rsp);
      sched_rsp_type p;
      int g;
      g = gap_len();
      // drop valid only across a gap, so back-to-back words keep it high
      if (g != 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid        <= 1;
      req_opcode       <= w.opcode;
      req_packet_count <= w.count;
      req_packet_slack <= w.slack;
      req_packet_value <= w.value;
      do @(posedge clock); while (!req_ready);
      p = apply_word(w);
      if (typed && p != typed_rsp) begin
         $display("%0t table row disagrees with model: typed %p model %p",
                  $time, typed_rsp, p);
         errors++;
      end
      pending_rsp = {pending_rsp, p};
   endtask

   task automatic write_capacity(int v);
      req_valid <= 0;
      // let the block drain; every word, arrivals included, gives a result that is waited for
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      psel <= 1; pwrite <= 1; penable <= 0;
      paddr <= 3'd0; pwdata <= v;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      m_cap = v & 7'h7F;
   endtask

   // result side: random stall, compare against oldest expectation
   initial begin
      sched_rsp_type e;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t unexpected result word", $time);
               errors++;
            end else begin
               e = pending_rsp.pop_front();
               if (rsp_sent !== e.sent || rsp_sent_value !== e.sent_value ||
                   rsp_was_empty !== e.was_empty || rsp_fill_level !== e.fill_level ||
                   rsp_arrived_total !== e.arrived_total ||
                   rsp_dropped_total !== e.dropped_total ||
                   rsp_sent_total !== e.sent_total || rsp_value_total !== e.value_total) begin
                  $display("%0t mismatch: expected %p", $time, e);
                  $display("   actual sent=%0d val=%0d empty=%0d fill=%0d arr=%0d drop=%0d sent=%0d vsum=%0d",
                           rsp_sent, rsp_sent_value, rsp_was_empty, rsp_fill_level,
                           rsp_arrived_total, rsp_dropped_total, rsp_sent_total,
                           rsp_value_total);
                  errors++;
               end
            end
         end
         if (stim_done && $urandom_range(0, 1)) rsp_ready <= 1;
         else if ($urandom_range(0, 19) == 0) rsp_ready <= 0;
         else if ($urandom_range(0, 2) == 0) rsp_ready <= ~rsp_ready;
         else rsp_ready <= 1;
      end
   end

   initial begin
      #200_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic sched_rsp_type mk(bit s, int sv, bit em, int fl, int ar, int dr,
                                        int st, longint vt);
      sched_rsp_type r;
      r.sent = s; r.sent_value = 16'(sv); r.was_empty = em; r.fill_level = 7'(fl);
      r.arrived_total = 32'(ar); r.dropped_total = 32'(dr); r.sent_total = 32'(st);
      r.value_total = 48'(vt);
      return r;
   endfunction

   function automatic dir_row_type row(bit op, int c, int sl, int v, bit t = 0,
                                       sched_rsp_type r = '{default: 0});
      dir_row_type d;
      d.w = '{op, 8'(c), 16'(sl), 16'(v)};
      d.typed = t;
      d.r = r;
      return d;
   endfunction

   initial begin
      dir_row_type dir_rows[$];
      pkt_word_type w;
      sched_rsp_type none;
      int caps[6] = '{1, 64, 127, 0, 3, 17};
      int base;
      m_occ = 0; m_arrived = 0; m_dropped = 0; m_sent = 0; m_vsum = 0;
      m_cap = CAPACITY_RESET;
      none = '{default: 0};
      repeat (4) @(posedge clock);
      reset <= 0;

      // capacity 4 after reset
      dir_rows = {dir_rows, row(OP_TICK, 0, 0, 0, 1, mk(0, 0, 1, 0, 0, 0, 0, 0))};
      dir_rows = {dir_rows, row(OP_ARRIVAL, 0, 5, 5, 1, mk(0, 0, 0, 0, 0, 0, 0, 0))};
      dir_rows = {dir_rows, row(OP_ARRIVAL, 255, 16'hFFFF, 16'hFFFF, 1,
                                mk(0, 0, 0, 4, 255, 251, 0, 0))};
      dir_rows = {dir_rows, row(OP_TICK, 0, 0, 0, 1,
                                mk(1, 16'hFFFF, 0, 3, 255, 251, 1, 16'hFFFF))};
      dir_rows = {dir_rows, row(OP_ARRIVAL, 2, 0, 16'h1234)};
      dir_rows = {dir_rows, row(OP_ARRIVAL, 1, 1, 16'h00AA)};
      dir_rows = {dir_rows, row(OP_ARRIVAL, 1, 2, 16'h5555)};
      dir_rows = {dir_rows, row(OP_ARRIVAL, 3, 1, 16'h8000)};
      dir_rows = {dir_rows, row(OP_TICK, 0, 0, 0)};
      dir_rows = {dir_rows, row(OP_TICK, 0, 0, 0)};
      dir_rows = {dir_rows, row(OP_TICK, 0, 0, 0)};
      dir_rows = {dir_rows, row(OP_ARRIVAL, 4, 1, 1)};
      dir_rows = {dir_rows, row(OP_TICK, 1, 16'hAAAA, 16'h5555)};
      dir_rows = {dir_rows, row(OP_TICK, 0, 0, 0)};
      foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r);

      // capacity lowered below occupancy, then extremes and random traffic
      write_capacity(64);
      for (int k = 0; k < 6; k++) begin
         w = '{OP_ARRIVAL, 8'd40, 16'(200 + k), 16'(10 + k)};
         send_word(w, 0, none);
      end
      write_capacity(2);
      send_word('{OP_ARRIVAL, 8'd1, 16'd500, 16'd77}, 0, none);
      send_word('{OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF}, 0, none);

      for (int ph = 0; ph < 6; ph++) begin
         write_capacity(caps[ph]);
         base = $urandom_range(1, 40);
         for (int n = 0; n < 125; n++) begin
            w.opcode = ($urandom_range(0, 2) == 0) ? OP_ARRIVAL : OP_TICK;
            w.count  = 8'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 6));
            w.slack  = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, base));
            w.value  = 16'($urandom_range(0, 65535));
            send_word(w, 0, none);
         end
      end
      req_valid <= 0;
      stim_done = 1;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

@@ files.f @@
sv/edf_pkg.sv
sv/edf_ram.sv
sv/edf_ctrl.sv
sv/edf_datapath.sv
sv/edf_packet_buffer_scheduler.sv
tb/tb_edf_packet_buffer_scheduler.sv
